// ===== rtl/afgp_pkg.sv =====
package afgp_pkg;

  localparam int unsigned NUM_COLS = 5;
  localparam int unsigned COL_W = 7;
  localparam int unsigned RX_W = 8;
  localparam int unsigned ID_W = 4;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 40;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [RX_W-1:0] MARK_BYTE = 8'h3A;
  localparam logic [RX_W-1:0] DIGIT_BASE = 8'h30;
  localparam logic [RX_W-1:0] DIGIT_LAST = 8'h39;
  localparam logic [RX_W-1:0] HEX_FIRST = 8'h41;
  localparam logic [RX_W-1:0] HEX_LAST = 8'h46;
  localparam logic [RX_W-1:0] HEX_OFFSET = 8'd10;
  localparam logic [RX_W-1:0] NODE_COUNT = 8'd6;

  typedef logic [RX_W-1:0] rx_byte_t;
  typedef logic [ID_W-1:0] node_id_t;
  typedef logic [COL_W-1:0] column_t;
  typedef logic [NUM_COLS-1:0][COL_W-1:0] glyph_t;
  typedef logic [3:0] glyph_idx_t;

  typedef enum logic [1:0] {
    PHASE_IDLE = 2'd0,
    PHASE_ID   = 2'd1,
    PHASE_CHAR = 2'd2
  } phase_t;

  typedef struct packed {
    logic   display_updated;
    logic   frame_started;
    logic   foreign_frame;
    glyph_t columns;
  } result_t;

  function automatic glyph_t font_glyph(input glyph_idx_t idx);
    glyph_t g;
    case (idx)
      4'd0:    g = {7'd62,  7'd71, 7'd73, 7'd113, 7'd62};
      4'd1:    g = {7'd1,   7'd1,  7'd127, 7'd65, 7'd33};
      4'd2:    g = {7'd33,  7'd81, 7'd73, 7'd69,  7'd35};
      4'd3:    g = {7'd54,  7'd73, 7'd73, 7'd73,  7'd65};
      4'd4:    g = {7'd8,   7'd127, 7'd8, 7'd8,   7'd120};
      4'd5:    g = {7'd70,  7'd73, 7'd73, 7'd73,  7'd121};
      4'd6:    g = {7'd70,  7'd73, 7'd73, 7'd73,  7'd62};
      4'd7:    g = {7'd112, 7'd72, 7'd68, 7'd66,  7'd65};
      4'd8:    g = {7'd54,  7'd73, 7'd73, 7'd73,  7'd54};
      4'd9:    g = {7'd62,  7'd73, 7'd73, 7'd73,  7'd50};
      4'd10:   g = {7'd31,  7'd36, 7'd68, 7'd36,  7'd31};
      4'd11:   g = {7'd54,  7'd73, 7'd73, 7'd73,  7'd127};
      4'd12:   g = {7'd34,  7'd65, 7'd65, 7'd65,  7'd62};
      4'd13:   g = {7'd62,  7'd65, 7'd65, 7'd65,  7'd127};
      4'd14:   g = {7'd73,  7'd73, 7'd73, 7'd73,  7'd127};
      4'd15:   g = {7'd72,  7'd72, 7'd72, 7'd72,  7'd127};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

// ===== rtl/afgp_font.sv =====
module afgp_font
  import afgp_pkg::*;
(
  input  rx_byte_t char_byte,
  output glyph_t   glyph
);

  rx_byte_t   digit_off;
  rx_byte_t   hex_off;
  glyph_idx_t idx;

  assign digit_off = char_byte - DIGIT_BASE;
  assign hex_off   = char_byte - HEX_FIRST + HEX_OFFSET;

  always_comb begin
    if (char_byte >= DIGIT_BASE && char_byte <= DIGIT_LAST) begin
      idx = digit_off[3:0];
    end else if (char_byte >= HEX_FIRST && char_byte <= HEX_LAST) begin
      idx = hex_off[3:0];
    end else begin
      idx = '0;
    end
  end

  assign glyph = font_glyph(idx);

endmodule

// ===== rtl/afgp_core.sv =====
module afgp_core
  import afgp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_wr_en,
  input  node_id_t cfg_wr_data,
  input  logic     step_en,
  input  rx_byte_t rx_byte,
  output result_t  res
);

  node_id_t own_id_r;
  phase_t   phase_r;
  phase_t   phase_nxt;
  glyph_t   display_r;
  glyph_t   display_nxt;
  glyph_t   glyph;
  rx_byte_t addr;

  afgp_font u_font (
    .char_byte (rx_byte),
    .glyph     (glyph)
  );

  assign addr = rx_byte - DIGIT_BASE;

  always_comb begin
    phase_nxt           = phase_r;
    display_nxt         = display_r;
    res.display_updated = 1'b0;
    res.frame_started   = 1'b0;
    res.foreign_frame   = 1'b0;
    if (rx_byte == MARK_BYTE) begin
      phase_nxt         = PHASE_ID;
      res.frame_started = 1'b1;
    end else begin
      case (phase_r)
        PHASE_ID: begin
          if (addr == {4'b0, own_id_r} || addr == NODE_COUNT) begin
            phase_nxt = PHASE_CHAR;
          end else begin
            phase_nxt         = PHASE_IDLE;
            res.foreign_frame = 1'b1;
          end
        end
        PHASE_CHAR: begin
          display_nxt         = glyph;
          res.display_updated = 1'b1;
          phase_nxt           = PHASE_IDLE;
        end
        default: begin
          phase_nxt = PHASE_IDLE;
        end
      endcase
    end
    res.columns = display_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_id_r  <= '0;
      phase_r   <= PHASE_IDLE;
      display_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        own_id_r <= cfg_wr_data;
      end
      if (step_en) begin
        phase_r   <= phase_nxt;
        display_r <= display_nxt;
      end
    end
  end

endmodule

// ===== rtl/addressed_frame_glyph_parser.sv =====
// Channel  | Ports                        | Contents
// ---------+------------------------------+-------------------------------------------
// in       | in_tvalid/in_tready/in_tdata | rx_byte [7:0]
// out      | out_tvalid/out_tready/       | tdata: column_0..column_4, 7 bits each,
//          | out_tdata/out_tuser          | zero pad [39:35]; tuser: display_updated,
//          |                              | frame_started, foreign_frame
// cfg      | cfg_wr_en/cfg_wr_data        | own_id [3:0]
//
// One beat per cycle sustained while the output is not stalled by out_tready.
// The path is an input register, then the parser and font lookup, then the result register.
// Synchronous active-low reset clears the phase, own_id and the display to blank.
// A stalled result holds in the result register; the input register still takes a byte if it is empty.
module addressed_frame_glyph_parser
  import afgp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // rx_byte
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // column_0, column_1, column_2, column_3, column_4
  output logic [OUT_TUSER_W-1:0] out_tuser,  // display_updated, frame_started, foreign_frame
  input  logic                   cfg_wr_en,
  input  logic [ID_W-1:0]        cfg_wr_data
);

  logic     in_valid_r;
  rx_byte_t in_byte_r;
  logic     out_valid_r;
  result_t  out_res_r;
  result_t  res;
  logic     step_en;

  assign step_en   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || step_en;

  afgp_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .rx_byte     (in_byte_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (step_en) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
    if (step_en) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_res_r.columns};
  assign out_tuser  = {out_res_r.foreign_frame, out_res_r.frame_started,
                       out_res_r.display_updated};

endmodule
